### design/audio_channel_downmix_top_defines.svh
// ---------------------------------------------------------------------------
// audio channel downmix assertion macros
// shared property forms for the downmix block checks
// ---------------------------------------------------------------------------
`ifndef AUDIO_CHANNEL_DOWNMIX_TOP_DEFINES_SVH
`define AUDIO_CHANNEL_DOWNMIX_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define ADM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define ADM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/adm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adm_pkg
// types and fixed constants of the channel downmix block
// ---------------------------------------------------------------------------
package adm_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;

  // channel count register and divisor widths
  localparam int COUNT_W = 7;
  localparam int DEN_W   = COUNT_W + 1;

  // downmix modes
  localparam logic MODE_MONO   = 1'b0;
  localparam logic MODE_STEREO = 1'b1;

  // result status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LENGTH = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CONFIG = 2'd3;

  // sequencer
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

endpackage

### design/audio_channel_downmix_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_channel_downmix_top
// interleaved sample downmix to mono or stereo pairs, rounded averages
// ---------------------------------------------------------------------------
//  channel | direction | tdata                    | tuser / tlast
//  in_     | slave     | sample                   | tlast = message_last
//  out_    | master    | mixed_sample             | tuser = out_channel, message_end,
//          |           |                          |   status; tlast = frame_last
//  cfg_    | slave     | index 0 mode, 1 count    | -
//
//  a plain sample is only absorbed; one that ends a message early or under an
//  unsupported layout sends its error result straight out
//  a closing sample runs, per result, load, one quotient bit a cycle on the
//  shared divider, hand-off: once in mono, left then right in stereo
//  rst_n is synchronous; each result also waits on out_tready, and in_tready
//  stays low from a beat that makes a result until it has left, or on cfg_valid
// ---------------------------------------------------------------------------
`include "audio_channel_downmix_top_defines.svh"

module audio_channel_downmix_top
  import adm_pkg::*;
#(
  parameter int MAX_CHANNELS = 64,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input samples
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,   // sample
  input  logic                              in_tlast,   // message_last
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]  out_tdata,  // mixed_sample
  output logic [3:0]                        out_tuser,  // out_channel, message_end, status[1:0]
  output logic                              out_tlast,  // frame_last
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int POS_W   = (MAX_CHANNELS > 2) ? $clog2(MAX_CHANNELS) : 1;
  // position compare width covers both the position and the 7-bit count
  localparam int CMP_W   = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;
  // accumulator holds MAX_CHANNELS full-range samples
  localparam int SUM_W   = SAMPLE_BITS + POS_W;
  // dividend 2*|sum| + n, half the divisor
  localparam int NUM_W   = SUM_W + 2;
  localparam int CNT_W   = $clog2(NUM_W);

  localparam logic signed [SAMPLE_BITS-1:0] ONE_S =
    {2'b01, {(SAMPLE_BITS-2){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] NEG_ONE_S =
    {2'b11, {(SAMPLE_BITS-2){1'b0}}};

  // configuration
  logic                    mode_r, mode_nxt;
  logic [COUNT_W-1:0]      count_r, count_nxt;

  // stream state
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [SUM_W-1:0] left_sum_r, left_sum_nxt;
  logic signed [SUM_W-1:0] right_sum_r, right_sum_nxt;
  logic [STATUS_W-1:0]     msg_status_r, msg_status_nxt;

  // sequencer and job
  state_t                  state_r, state_nxt;
  logic                    job_last_r, job_last_nxt;    // frame closed by message_last
  logic                    job_right_r, job_right_nxt;  // divide works on right sum
  logic                    job_avg_r, job_avg_nxt;      // result is an average, not an error

  // shared divider
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic [DEN_W-1:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]  out_data_r, out_data_nxt;
  logic                    out_chan_r, out_chan_nxt;
  logic                    out_flast_r, out_flast_nxt;
  logic                    out_mend_r, out_mend_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;

  // handshakes
  logic in_fire, out_fire, cfg_fire;
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_tready = (state_r == ST_IDLE) && !cfg_valid;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // sample decode and frame bookkeeping
  logic signed [SAMPLE_BITS-1:0] sample_s;
  logic                          range_bad;
  logic                          supported;
  logic                          frame_done;
  logic [CMP_W-1:0]              pos_ext, count_ext;
  assign sample_s   = $signed(in_tdata[SAMPLE_BITS-1:0]);
  assign range_bad  = (sample_s > ONE_S) || (sample_s < NEG_ONE_S);
  assign pos_ext    = CMP_W'(pos_r);
  assign count_ext  = CMP_W'(count_r);
  assign frame_done = (pos_ext + CMP_W'(1)) == count_ext;

  always_comb begin
    supported = 1'b0;
    if (32'(count_r) <= MAX_CHANNELS) begin
      if (mode_r == MODE_MONO) begin
        supported = (count_r >= COUNT_W'(2));
      end else begin
        supported = (count_r >= COUNT_W'(4)) && !count_r[0];
      end
    end
  end

  // divisor is 2*n, with n the channel count or half of it in pair mode
  logic [COUNT_W-1:0] div_n;
  logic [DEN_W-1:0]   den;
  assign div_n = (mode_r == MODE_STEREO) ? (count_r >> 1) : count_r;
  assign den   = {div_n, 1'b0};

  // operand pick and magnitude for loading the divider
  logic signed [SUM_W-1:0] op_sum;
  logic [SUM_W-1:0]        op_mag;
  assign op_sum = job_right_r ? right_sum_r : left_sum_r;
  assign op_mag = op_sum[SUM_W-1] ? (~op_sum + SUM_W'(1)) : op_sum;

  // one restoring step: one quotient bit a cycle
  logic [DEN_W:0]          trial;
  logic                    q_bit;
  logic [NUM_W-1:0]        quot;
  logic [SAMPLE_BITS-1:0]  q_trunc;
  assign trial   = {rem_r, num_r[NUM_W-1]};
  assign q_bit   = (trial >= {1'b0, den});
  assign quot    = {num_r[NUM_W-2:0], q_bit};
  assign q_trunc = quot[SAMPLE_BITS-1:0];

  always_comb begin
    mode_nxt       = mode_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    left_sum_nxt   = left_sum_r;
    right_sum_nxt  = right_sum_r;
    msg_status_nxt = msg_status_r;
    state_nxt      = state_r;
    job_last_nxt   = job_last_r;
    job_right_nxt  = job_right_r;
    job_avg_nxt    = job_avg_r;
    num_nxt        = num_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_chan_nxt   = out_chan_r;
    out_flast_nxt  = out_flast_r;
    out_mend_nxt   = out_mend_r;
    out_status_nxt = out_status_r;

    case (state_r)
      ST_IDLE: begin
        if (cfg_fire) begin
          // a known register write drops any partial frame
          if (cfg_index == REG_MODE || cfg_index == REG_COUNT) begin
            if (cfg_index == REG_MODE) begin
              mode_nxt = cfg_data[0];
            end else begin
              count_nxt = cfg_data[COUNT_W-1:0];
            end
            pos_nxt        = '0;
            left_sum_nxt   = '0;
            right_sum_nxt  = '0;
            msg_status_nxt = STATUS_OK;
          end
        end else if (in_fire) begin
          if (!supported) begin
            // samples absorbed, end of message reports the config fault
            if (in_tlast) begin
              pos_nxt        = '0;
              left_sum_nxt   = '0;
              right_sum_nxt  = '0;
              msg_status_nxt = STATUS_OK;
              job_avg_nxt    = 1'b0;
              out_valid_nxt  = 1'b1;
              out_data_nxt   = '0;
              out_chan_nxt   = 1'b0;
              out_flast_nxt  = 1'b1;
              out_mend_nxt   = 1'b1;
              out_status_nxt = STATUS_CONFIG;
              state_nxt      = ST_OUT;
            end
          end else begin
            if (range_bad) begin
              msg_status_nxt = STATUS_RANGE;
            end
            if (mode_r == MODE_STEREO && pos_r[0]) begin
              right_sum_nxt = right_sum_r + SUM_W'(sample_s);
            end else begin
              left_sum_nxt = left_sum_r + SUM_W'(sample_s);
            end
            if (!frame_done) begin
              pos_nxt = pos_r + POS_W'(1);
              if (in_tlast) begin
                // message ended inside a frame
                pos_nxt        = '0;
                left_sum_nxt   = '0;
                right_sum_nxt  = '0;
                msg_status_nxt = STATUS_OK;
                job_avg_nxt    = 1'b0;
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_chan_nxt   = 1'b0;
                out_flast_nxt  = 1'b1;
                out_mend_nxt   = 1'b1;
                out_status_nxt = STATUS_LENGTH;
                state_nxt      = ST_OUT;
              end
            end else begin
              job_last_nxt  = in_tlast;
              job_right_nxt = 1'b0;
              job_avg_nxt   = 1'b1;
              state_nxt     = ST_LOAD;
            end
          end
        end
      end

      ST_LOAD: begin
        // dividend 2*|sum| + n over divisor 2*n rounds half away from zero
        num_nxt   = {1'b0, op_mag, 1'b0} + NUM_W'(div_n);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        neg_nxt   = op_sum[SUM_W-1];
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        num_nxt = quot;
        rem_nxt = q_bit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = (msg_status_r != STATUS_OK) ? '0 :
                           (neg_r ? (~q_trunc + SAMPLE_BITS'(1)) : q_trunc);
          out_chan_nxt   = job_right_r;
          out_flast_nxt  = (mode_r == MODE_MONO) || job_right_r;
          out_mend_nxt   = job_last_r && ((mode_r == MODE_MONO) || job_right_r);
          out_status_nxt = msg_status_r;
          state_nxt      = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
          if (job_avg_r) begin
            if (mode_r == MODE_STEREO && !job_right_r) begin
              // left done, now the right sum
              job_right_nxt = 1'b1;
              state_nxt     = ST_LOAD;
            end else begin
              pos_nxt       = '0;
              left_sum_nxt  = '0;
              right_sum_nxt = '0;
              if (job_last_r) begin
                msg_status_nxt = STATUS_OK;
              end
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_MONO;
      count_r      <= COUNT_W'(2);
      pos_r        <= '0;
      left_sum_r   <= '0;
      right_sum_r  <= '0;
      msg_status_r <= STATUS_OK;
      state_r      <= ST_IDLE;
      job_last_r   <= 1'b0;
      job_right_r  <= 1'b0;
      job_avg_r    <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      count_r      <= count_nxt;
      pos_r        <= pos_nxt;
      left_sum_r   <= left_sum_nxt;
      right_sum_r  <= right_sum_nxt;
      msg_status_r <= msg_status_nxt;
      state_r      <= state_nxt;
      job_last_r   <= job_last_nxt;
      job_right_r  <= job_right_nxt;
      job_avg_r    <= job_avg_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // divider datapath and result payload
  always_ff @(posedge clk) begin
    num_r        <= num_nxt;
    rem_r        <= rem_nxt;
    neg_r        <= neg_nxt;
    out_data_r   <= out_data_nxt;
    out_chan_r   <= out_chan_nxt;
    out_flast_r  <= out_flast_nxt;
    out_mend_r   <= out_mend_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);
  assign out_tuser  = {out_status_r, out_mend_r, out_chan_r};
  assign out_tlast  = out_flast_r;

  // checks
  `ADM_ASSERT_NOW(a_err_zero, out_valid_r && out_status_r != STATUS_OK, out_data_r == '0, "non-ok result carries data")
  `ADM_ASSERT_NOW(a_one_beat, in_tready, !out_valid_r, "input taken while a result is pending")
  `ADM_ASSERT_NOW(a_left_first, out_valid_r && !out_flast_r, mode_r == MODE_STEREO && !out_chan_r, "open frame result not a left channel")
  `ADM_ASSERT_NOW(a_pos_bound, state_r == ST_IDLE && supported, pos_ext < count_ext, "frame position past channel count")
  `ADM_ASSERT_NEXT(a_div_done, state_r == ST_DIV && cnt_r == CNT_W'(NUM_W - 1), out_valid_r && state_r == ST_OUT, "divide end without result")

endmodule
